// ----- hw/rtl/tlc_pkg.sv -----
// shared constants and types for the two-level cache tag lookup
package tlc_pkg;

  localparam int unsigned ADDR_W             = 32;
  localparam int unsigned LINE_BYTES         = 64;
  localparam int unsigned FIRST_LEVEL_LINES  = 1024;
  localparam int unsigned SECOND_LEVEL_LINES = 65536;

  localparam int unsigned OFF_W    = $clog2(LINE_BYTES);
  localparam int unsigned TAG_W    = ADDR_W - OFF_W;
  localparam int unsigned L1_IDX_W = $clog2(FIRST_LEVEL_LINES);
  localparam int unsigned L2_IDX_W = $clog2(SECOND_LEVEL_LINES);

  typedef enum logic [1:0] {
    OUTCOME_L1_HIT = 2'd0,
    OUTCOME_L2_HIT = 2'd1,
    OUTCOME_MISS   = 2'd2
  } outcome_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } tag_entry_t;

endpackage

// ----- hw/rtl/tlc_if.sv -----
// request and result channel interfaces
interface tlc_req_if;
  logic                      valid;
  logic                      ready;
  logic [tlc_pkg::ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface tlc_res_if;
  logic              valid;
  logic              ready;
  tlc_pkg::outcome_t outcome;

  modport source (output valid, output outcome, input ready);
  modport sink   (input valid, input outcome, output ready);
endinterface

// ----- hw/rtl/two_level_cache_tag_lookup.sv -----
// two-level direct-mapped cache tag lookup with hit classification
//
// in_req carries one byte address per request; out_res returns one outcome per
// request, in order: L1 hit, L2 hit (L1 entry filled) or miss (both filled).
// both channels use valid/ready; a request moves when both are high.
// throughput: one request per cycle while out_res does not stall. the L1 and
// L2 tag memories are each read in the accept cycle and written back as the
// request leaves the lookup stage; a request that reads an entry written at
// its own accept edge gets the new entry forwarded.
// reset: after rst_n a clearing pass walks the L2 memory, one entry a cycle,
// over all SECOND_LEVEL_LINES (65536) entries, and clears the L1 memory
// alongside it. in_req.ready stays low until the pass is done.
// a stalled receiver holds the result in the output register; one more
// request may be taken into the lookup stage, then in_req.ready drops.
module two_level_cache_tag_lookup (
  input  logic           clk,
  input  logic           rst_n,
  tlc_req_if.sink        in_req,
  tlc_res_if.source      out_res
);

  localparam int unsigned TAG_W    = tlc_pkg::TAG_W;
  localparam int unsigned L1_IDX_W = tlc_pkg::L1_IDX_W;
  localparam int unsigned L2_IDX_W = tlc_pkg::L2_IDX_W;
  localparam logic [L2_IDX_W-1:0] CLR_LAST = L2_IDX_W'(tlc_pkg::SECOND_LEVEL_LINES - 1);

  tlc_pkg::tag_entry_t l1_mem [tlc_pkg::FIRST_LEVEL_LINES];
  tlc_pkg::tag_entry_t l2_mem [tlc_pkg::SECOND_LEVEL_LINES];

  logic                clearing_r;
  logic [L2_IDX_W-1:0] clr_cnt_r;

  logic                s1_valid_r;
  logic [TAG_W-1:0]    s1_line_r;
  tlc_pkg::tag_entry_t l1_rd_r;
  tlc_pkg::tag_entry_t l2_rd_r;

  logic                fwd1_v_r;
  logic [L1_IDX_W-1:0] fwd1_idx_r;
  logic                fwd2_v_r;
  logic [L2_IDX_W-1:0] fwd2_idx_r;
  logic [TAG_W-1:0]    fwd_line_r;

  logic              out_valid_r;
  tlc_pkg::outcome_t out_outcome_r;

  logic                in_acc;
  logic                out_free;
  logic                s1_adv;
  logic [TAG_W-1:0]    in_line;
  logic [L1_IDX_W-1:0] in_i1;
  logic [L2_IDX_W-1:0] in_i2;
  logic [L1_IDX_W-1:0] s1_i1;
  logic [L2_IDX_W-1:0] s1_i2;
  tlc_pkg::tag_entry_t l1_ent;
  tlc_pkg::tag_entry_t l2_ent;
  logic                hit1;
  logic                hit2;
  tlc_pkg::outcome_t   s1_outcome;
  logic                l1_we;
  logic                l2_we;
  logic [L1_IDX_W-1:0] l1_wa;
  logic [L2_IDX_W-1:0] l2_wa;
  tlc_pkg::tag_entry_t wr_ent;

  assign out_free     = !out_valid_r || out_res.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_req.ready = !clearing_r && (!s1_valid_r || out_free);
  assign in_acc       = in_req.valid && in_req.ready;

  assign in_line = in_req.address[tlc_pkg::ADDR_W-1:tlc_pkg::OFF_W];
  assign in_i1   = in_line[L1_IDX_W-1:0];
  assign in_i2   = in_line[L2_IDX_W-1:0];
  assign s1_i1   = s1_line_r[L1_IDX_W-1:0];
  assign s1_i2   = s1_line_r[L2_IDX_W-1:0];

  // entries written at this request's read edge are not in the read data yet
  always_comb begin
    l1_ent = l1_rd_r;
    l2_ent = l2_rd_r;
    if (fwd1_v_r && fwd1_idx_r == s1_i1) begin
      l1_ent.valid = 1'b1;
      l1_ent.tag   = fwd_line_r;
    end
    if (fwd2_v_r && fwd2_idx_r == s1_i2) begin
      l2_ent.valid = 1'b1;
      l2_ent.tag   = fwd_line_r;
    end
    hit1 = l1_ent.valid && (l1_ent.tag == s1_line_r);
    hit2 = l2_ent.valid && (l2_ent.tag == s1_line_r);
    if (hit1) begin
      s1_outcome = tlc_pkg::OUTCOME_L1_HIT;
    end else if (hit2) begin
      s1_outcome = tlc_pkg::OUTCOME_L2_HIT;
    end else begin
      s1_outcome = tlc_pkg::OUTCOME_MISS;
    end
  end

  always_comb begin
    if (clearing_r) begin
      l1_we        = 1'b1;
      l2_we        = 1'b1;
      l1_wa        = clr_cnt_r[L1_IDX_W-1:0];
      l2_wa        = clr_cnt_r;
      wr_ent.valid = 1'b0;
      wr_ent.tag   = '0;
    end else begin
      l1_we        = s1_adv && !hit1;
      l2_we        = s1_adv && !hit1 && !hit2;
      l1_wa        = s1_i1;
      l2_wa        = s1_i2;
      wr_ent.valid = 1'b1;
      wr_ent.tag   = s1_line_r;
    end
  end

  // tag memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (l1_we) begin
      l1_mem[l1_wa] <= wr_ent;
    end
    if (l2_we) begin
      l2_mem[l2_wa] <= wr_ent;
    end
    if (in_acc) begin
      l1_rd_r <= l1_mem[in_i1];
      l2_rd_r <= l2_mem[in_i2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      fwd1_v_r    <= 1'b0;
      fwd2_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          clearing_r <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        fwd1_v_r   <= l1_we && !clearing_r;
        fwd2_v_r   <= l2_we && !clearing_r;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_line_r  <= in_line;
      fwd1_idx_r <= s1_i1;
      fwd2_idx_r <= s1_i2;
      fwd_line_r <= s1_line_r;
    end
    if (s1_adv) begin
      out_outcome_r <= s1_outcome;
    end
  end

  assign out_res.valid   = out_valid_r;
  assign out_res.outcome = out_outcome_r;

  a_no_req_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_acc)
    else $error("request accepted during clearing pass");

  a_miss_fills_both : assert property (@(posedge clk) disable iff (!rst_n)
    (l2_we && !clearing_r) |-> (l1_we && s1_adv))
    else $error("L2 fill without matching L1 fill");

  a_fill_forwarded : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_adv && !hit1) |=> fwd1_v_r)
    else $error("L1 fill at read edge not marked for forwarding");

  a_result_follows_lookup : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_valid_r && out_outcome_r == $past(s1_outcome)))
    else $error("lookup result not captured in output register");

endmodule

// ----- tb/sv/tlc_lookup_checker.sv -----
// passive checker: predicts each lookup outcome and compares it with the result channel
`timescale 1ns / 1ps

module tlc_lookup_checker (
  input  logic        clk,
  input  logic        rst_n,
  tlc_req_if          req,
  tlc_res_if          res,
  output int unsigned fail_count,
  output int unsigned expected_count
);

  localparam int unsigned ADDR_W = tlc_pkg::ADDR_W;
  localparam int unsigned OFF_W  = tlc_pkg::OFF_W;
  localparam int unsigned TAG_W  = tlc_pkg::TAG_W;

  bit               l1_valid [tlc_pkg::FIRST_LEVEL_LINES];
  logic [TAG_W-1:0] l1_line  [tlc_pkg::FIRST_LEVEL_LINES];
  bit               l2_valid [tlc_pkg::SECOND_LEVEL_LINES];
  logic [TAG_W-1:0] l2_line  [tlc_pkg::SECOND_LEVEL_LINES];

  tlc_pkg::outcome_t pending_outcomes [$];
  tlc_pkg::outcome_t oldest_outcome;

  // classify one access and update the tag copies the way the cache does
  function automatic tlc_pkg::outcome_t classify_access(input logic [ADDR_W-1:0] addr);
    logic [TAG_W-1:0] ln;
    int unsigned      i1;
    int unsigned      i2;
    ln = addr[ADDR_W-1:OFF_W];
    i1 = 32'(ln) % tlc_pkg::FIRST_LEVEL_LINES;
    i2 = 32'(ln) % tlc_pkg::SECOND_LEVEL_LINES;
    if (l1_valid[i1] && l1_line[i1] == ln) begin
      return tlc_pkg::OUTCOME_L1_HIT;
    end
    if (l2_valid[i2] && l2_line[i2] == ln) begin
      l1_valid[i1] = 1'b1;
      l1_line[i1]  = ln;
      return tlc_pkg::OUTCOME_L2_HIT;
    end
    l2_valid[i2] = 1'b1;
    l2_line[i2]  = ln;
    l1_valid[i1] = 1'b1;
    l1_line[i1]  = ln;
    return tlc_pkg::OUTCOME_MISS;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (l1_valid[i]) l1_valid[i] = 1'b0;
      foreach (l2_valid[i]) l2_valid[i] = 1'b0;
      pending_outcomes.delete();
      fail_count = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("outcome: no request outstanding, actual %0d", res.outcome);
          fail_count++;
        end else begin
          oldest_outcome = pending_outcomes.pop_front();
          if (res.outcome !== oldest_outcome) begin
            $error("outcome mismatch: expected %0d actual %0d", oldest_outcome, res.outcome);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_outcomes.push_back(classify_access(req.address));
      end
    end
    expected_count = unsigned'(pending_outcomes.size());
  end

endmodule

// ----- tb/sv/tb_two_level_cache_tag_lookup.sv -----
// top of the cache tag lookup testbench: clock, reset, address stimulus and verdict
`timescale 1ns / 1ps

module tb_two_level_cache_tag_lookup;

  localparam int unsigned ADDR_W             = tlc_pkg::ADDR_W;
  localparam int unsigned OFF_W              = tlc_pkg::OFF_W;
  localparam int unsigned TAG_W              = tlc_pkg::TAG_W;
  localparam int unsigned FIRST_LEVEL_LINES  = tlc_pkg::FIRST_LEVEL_LINES;
  localparam int unsigned SECOND_LEVEL_LINES = tlc_pkg::SECOND_LEVEL_LINES;

  localparam int unsigned RANDOM_REQUESTS = 1450;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned HISTORY_DEPTH   = 48;

  logic clk;
  logic rst_n;
  bit   source_gaps;
  bit   sink_stalls;

  int unsigned chk_fails;
  int unsigned chk_expected;
  int unsigned cycle_count;

  logic [TAG_W-1:0] recent_lines [$];

  // cold miss, same-line hit, top of memory, L1 conflict, L2 refill, both-level conflict
  logic [ADDR_W-1:0] directed_addrs [$] = '{
    32'h0000_0000, 32'h0000_003F, 32'hFFFF_FFFF, 32'hFFFF_FFC0,
    32'h0000_0040, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0040_0000, 32'h0000_0010, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000
  };

  tlc_req_if in_req ();
  tlc_res_if out_res ();

  two_level_cache_tag_lookup dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  tlc_lookup_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (in_req),
    .res            (out_res),
    .fail_count     (chk_fails),
    .expected_count (chk_expected)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_res.ready <= !(sink_stalls && $urandom_range(0, 99) < 17);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_request(input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    while (source_gaps && $urandom_range(0, 99) < 17) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid   <= 1'b1;
    in_req.address <= addr;
    do @(posedge clk); while (!in_req.ready);
    recent_lines.push_back(addr[ADDR_W-1:OFF_W]);
    if (recent_lines.size() > HISTORY_DEPTH) void'(recent_lines.pop_front());
  endtask

  // mostly lines seen lately, or lines that collide with them in one or both levels
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [TAG_W-1:0] ln;
    logic [OFF_W-1:0] off;
    int unsigned      sel;
    sel = $urandom_range(0, 99);
    off = OFF_W'($urandom);
    if (recent_lines.size() == 0 || sel >= 80) return $urandom;
    ln = recent_lines[$urandom_range(0, recent_lines.size() - 1)];
    if (sel < 35) begin
      // plain reuse
    end else if (sel < 55) begin
      ln = ln + TAG_W'(FIRST_LEVEL_LINES *
                       $urandom_range(1, SECOND_LEVEL_LINES / FIRST_LEVEL_LINES - 1));
    end else if (sel < 65) begin
      ln = ln + TAG_W'(SECOND_LEVEL_LINES * $urandom_range(1, 15));
    end else begin
      ln = TAG_W'($urandom_range(0, 2 * FIRST_LEVEL_LINES - 1));
    end
    return {ln, off};
  endfunction

  // stop offering requests and wait until every outcome has come back
  task automatic drain_results();
    @(negedge clk);
    in_req.valid <= 1'b0;
    wait (chk_expected == 0);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_req.valid   = 1'b0;
    in_req.address = '0;
    source_gaps    = 1'b0;
    sink_stalls    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // back to back, so fills are forwarded to the following request
    foreach (directed_addrs[i]) send_request(directed_addrs[i]);
    drain_results();

    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      source_gaps = !(n >= 600 && n < 900);
      sink_stalls = !(n >= 600 && n < 900);
      if (n == 1000) drain_results();
      send_request(pick_address());
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (chk_fails == 0 && chk_expected == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
